// ===== design/gwwp_pkg.sv =====
// shared types and constants of the greedy word wrap pager
package gwwp_pkg;

    // parameter defaults
    localparam int MAX_LINE_WIDTH_DEF = 16;
    localparam int MAX_PAGES_DEF      = 32;
    localparam int MAX_ROWS_DEF       = 4;

    // covers the largest supported line width
    localparam int WORD_LEN_W = 6;

    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [7:0] SEP_CODE = 8'd32;
    localparam logic [7:0] NUL_CODE = 8'd0;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_PAGE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_LIMIT    = 2'd2;

    localparam logic [4:0] LINE_WIDTH_RST    = 5'd16;
    localparam logic [2:0] ROWS_PER_PAGE_RST = 3'd2;
    localparam logic [5:0] PAGE_LIMIT_RST    = 6'd20;

    typedef struct packed {
        logic [4:0] line_width;
        logic [2:0] rows_per_page;
        logic [5:0] page_limit;
    } cfg_t;

    // one closed word (or bare end of text) handed to the layout side
    typedef struct packed {
        logic                  bank;
        logic [WORD_LEN_W-1:0] len;
        logic                  too_long;
        logic                  eot;
    } cmd_t;

    // layout side is done reading a word buffer bank
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

// ===== design/gwwp_ram.sv =====
// generic single write port ram with registered read
module gwwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gwwp_front.sv =====
// input side: collects characters into word buffers and closes words
module gwwp_front #(
    parameter int MAX_LINE_WIDTH = gwwp_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            glyph,
    input  logic                                  end_of_text,
    output logic                                  q_push,
    output gwwp_pkg::cmd_t                        q_data,
    input  logic                                  q_full,
    input  gwwp_pkg::rel_t                        rel,
    output logic                                  ram_we,
    output logic [$clog2(2*MAX_LINE_WIDTH)-1:0]   ram_waddr,
    output logic [7:0]                            ram_wdata
);

    localparam int LW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int IW = $clog2(MAX_LINE_WIDTH);
    localparam int AW = $clog2(2 * MAX_LINE_WIDTH);

    logic          bank_reg, bank_next;
    logic [LW-1:0] len_reg, len_next;
    logic          tl_reg, tl_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic          is_sep;
    logic          has_room;
    logic          closes;
    logic [LW-1:0] len_new;
    logic          tl_new;

    assign in_ready = !q_full && !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;
    assign is_sep   = (glyph == gwwp_pkg::SEP_CODE) || (glyph == gwwp_pkg::NUL_CODE);
    assign has_room = len_reg < LW'(MAX_LINE_WIDTH);
    assign closes   = end_of_text || (is_sep && ((len_reg != '0) || tl_reg));

    always_comb
    begin
        len_new = len_reg;
        tl_new  = tl_reg;
        if (!is_sep)
        begin
            if (has_room)
            begin
                len_new = len_reg + LW'(1);
            end
            else
            begin
                tl_new = 1'b1;
            end
        end
    end

    assign q_push          = accept && closes;
    assign q_data.bank     = bank_reg;
    assign q_data.len      = gwwp_pkg::WORD_LEN_W'(len_new);
    assign q_data.too_long = tl_new;
    assign q_data.eot      = end_of_text;

    assign ram_we    = accept && !is_sep && has_room;
    assign ram_waddr = (bank_reg ? AW'(MAX_LINE_WIDTH) : AW'(0)) + AW'(len_reg[IW-1:0]);
    assign ram_wdata = glyph;

    always_comb
    begin
        bank_next = bank_reg;
        len_next  = len_reg;
        tl_next   = tl_reg;
        busy_next = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (closes)
            begin
                len_next = '0;
                tl_next  = 1'b0;
                // only a bank holding characters is locked and swapped
                if (len_new != '0)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                end
            end
            else
            begin
                len_next = len_new;
                tl_next  = tl_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            len_reg  <= '0;
            tl_reg   <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
            len_reg  <= len_next;
            tl_reg   <= tl_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== design/gwwp_cmd_fifo.sv =====
// short queue of closed words between input side and layout side
module gwwp_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gwwp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output gwwp_pkg::cmd_t head_data
);

    localparam int DEPTH = gwwp_pkg::CMD_FIFO_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    gwwp_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = count_reg == CNTW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/gwwp_back.sv =====
// layout side: places closed words on the page grid and emits cells
module gwwp_back #(
    parameter int MAX_LINE_WIDTH = gwwp_pkg::MAX_LINE_WIDTH_DEF,
    parameter int MAX_PAGES      = gwwp_pkg::MAX_PAGES_DEF,
    parameter int MAX_ROWS       = gwwp_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gwwp_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  gwwp_pkg::cmd_t                      q_data,
    output logic                                q_pop,
    output gwwp_pkg::rel_t                      rel,
    output logic                                ram_re,
    output logic [$clog2(2*MAX_LINE_WIDTH)-1:0] ram_raddr,
    input  logic [7:0]                          ram_rdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [4:0]                          page_index,
    output logic [1:0]                          row_index,
    output logic [3:0]                          column_index,
    output logic [7:0]                          cell_char,
    output logic                                is_summary,
    output logic [5:0]                          page_count,
    output logic                                overflow,
    output logic                                last
);

    localparam int CW   = $clog2(MAX_LINE_WIDTH + 1);
    localparam int SUMW = CW + 2;
    localparam int IW   = $clog2(MAX_LINE_WIDTH);
    localparam int AW   = $clog2(2 * MAX_LINE_WIDTH);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int RCW  = ((RW > 3) ? RW : 3) + 1;
    localparam int PW   = $clog2(MAX_PAGES + 1);
    localparam int PCW  = ((PW > 6) ? PW : 6) + 1;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_PLACE = 6'b000010,
        B_SEP   = 6'b000100,
        B_RD    = 6'b001000,
        B_EMIT  = 6'b010000,
        B_SUM   = 6'b100000
    } back_state_t;

    back_state_t     state_reg, state_next;
    gwwp_pkg::cmd_t  cmd_reg, cmd_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [PW-1:0]   page_reg, page_next;
    logic            placed_reg, placed_next;
    logic            dropped_reg, dropped_next;
    logic [IW-1:0]   idx_reg, idx_next;

    logic            ov_reg, ov_next;
    logic [4:0]      opage_reg, opage_next;
    logic [1:0]      orow_reg, orow_next;
    logic [3:0]      ocol_reg, ocol_next;
    logic [7:0]      ochar_reg, ochar_next;
    logic            osum_reg, osum_next;
    logic [5:0]      ocount_reg, ocount_next;
    logic            oovf_reg, oovf_next;
    logic            olast_reg, olast_next;

    // effective configuration
    logic [SUMW-1:0] lw_cfg, lw_eff;
    logic [RCW-1:0]  rows_cfg, rows_eff;
    logic [PCW-1:0]  pl_cfg, pl_eff;

    // placement of the held word
    logic [CW-1:0]   w;
    logic            sep;
    logic [SUMW-1:0] span;
    logic            wrap;
    logic [RCW-1:0]  row_inc;
    logic            row_wrap;
    logic [PCW-1:0]  pg_n;
    logic [RCW-1:0]  row_n;
    logic            is_empty;
    logic            long_drop;
    logic            page_drop;
    logic            out_free;
    logic            last_char;

    assign lw_cfg   = SUMW'(cfg.line_width);
    assign lw_eff   = (lw_cfg < SUMW'(MAX_LINE_WIDTH)) ? lw_cfg : SUMW'(MAX_LINE_WIDTH);
    assign rows_cfg = RCW'(cfg.rows_per_page);
    assign rows_eff = (rows_cfg == '0) ? RCW'(1)
                    : ((rows_cfg > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_cfg);
    assign pl_cfg   = PCW'(cfg.page_limit);
    assign pl_eff   = (pl_cfg < PCW'(MAX_PAGES)) ? pl_cfg : PCW'(MAX_PAGES);

    assign w         = CW'(cmd_reg.len);
    assign sep       = col_reg != '0;
    assign span      = SUMW'(col_reg) + SUMW'(sep) + SUMW'(w);
    assign wrap      = span > lw_eff;
    assign row_inc   = RCW'(row_reg) + RCW'(1);
    assign row_wrap  = wrap && (row_inc >= rows_eff);
    assign pg_n      = PCW'(page_reg) + PCW'(row_wrap);
    assign row_n     = wrap ? (row_wrap ? '0 : row_inc) : RCW'(row_reg);
    assign is_empty  = (w == '0) && !cmd_reg.too_long;
    assign long_drop = cmd_reg.too_long || (SUMW'(w) > lw_eff);
    assign page_drop = pg_n >= pl_eff;
    assign out_free  = !ov_reg || out_ready;
    assign last_char = (CW'(idx_reg) + CW'(1)) == w;

    assign ram_raddr = (cmd_reg.bank ? AW'(MAX_LINE_WIDTH) : AW'(0)) + AW'(idx_reg);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        page_next    = page_reg;
        placed_next  = placed_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg && !out_ready;
        opage_next   = opage_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        ochar_next   = ochar_reg;
        osum_next    = osum_reg;
        ocount_next  = ocount_reg;
        oovf_next    = oovf_reg;
        olast_next   = olast_reg;
        q_pop        = 1'b0;
        rel.valid    = 1'b0;
        rel.bank     = cmd_reg.bank;
        ram_re       = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_data;
                    q_pop      = 1'b1;
                    state_next = B_PLACE;
                end
            end
            B_PLACE:
            begin
                idx_next = '0;
                if (is_empty)
                begin
                    state_next = cmd_reg.eot ? B_SUM : B_IDLE;
                end
                else if (long_drop)
                begin
                    dropped_next = 1'b1;
                    rel.valid    = 1'b1;
                    state_next   = cmd_reg.eot ? B_SUM : B_IDLE;
                end
                else if (page_drop)
                begin
                    // pin the cursor so every later word of the text drops too
                    dropped_next = 1'b1;
                    row_next     = RW'(rows_eff - RCW'(1));
                    col_next     = CW'(MAX_LINE_WIDTH);
                    rel.valid    = 1'b1;
                    state_next   = cmd_reg.eot ? B_SUM : B_IDLE;
                end
                else
                begin
                    page_next   = PW'(pg_n);
                    row_next    = RW'(row_n);
                    col_next    = wrap ? '0 : col_reg;
                    placed_next = 1'b1;
                    state_next  = (sep && !wrap) ? B_SEP : B_RD;
                end
            end
            B_SEP:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    opage_next  = 5'(page_reg);
                    orow_next   = 2'(row_reg);
                    ocol_next   = 4'(col_reg);
                    ochar_next  = gwwp_pkg::SEP_CODE;
                    osum_next   = 1'b0;
                    ocount_next = '0;
                    oovf_next   = 1'b0;
                    olast_next  = 1'b0;
                    col_next    = col_reg + CW'(1);
                    state_next  = B_RD;
                end
            end
            B_RD:
            begin
                ram_re     = 1'b1;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    opage_next  = 5'(page_reg);
                    orow_next   = 2'(row_reg);
                    ocol_next   = 4'(col_reg);
                    ochar_next  = ram_rdata;
                    osum_next   = 1'b0;
                    ocount_next = '0;
                    oovf_next   = 1'b0;
                    olast_next  = last_char && !cmd_reg.eot;
                    col_next    = col_reg + CW'(1);
                    idx_next    = idx_reg + IW'(1);
                    if (last_char)
                    begin
                        rel.valid  = 1'b1;
                        state_next = cmd_reg.eot ? B_SUM : B_IDLE;
                    end
                    else
                    begin
                        state_next = B_RD;
                    end
                end
            end
            B_SUM:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    opage_next   = '0;
                    orow_next    = '0;
                    ocol_next    = '0;
                    ochar_next   = '0;
                    osum_next    = 1'b1;
                    ocount_next  = placed_reg ? 6'(PCW'(page_reg) + PCW'(1)) : '0;
                    oovf_next    = dropped_reg;
                    olast_next   = 1'b1;
                    // start a fresh text
                    col_next     = '0;
                    row_next     = '0;
                    page_next    = '0;
                    placed_next  = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            page_reg    <= '0;
            placed_reg  <= 1'b0;
            dropped_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            page_reg    <= page_next;
            placed_reg  <= placed_next;
            dropped_reg <= dropped_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        opage_reg  <= opage_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        ochar_reg  <= ochar_next;
        osum_reg   <= osum_next;
        ocount_reg <= ocount_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = ov_reg;
    assign page_index   = opage_reg;
    assign row_index    = orow_reg;
    assign column_index = ocol_reg;
    assign cell_char    = ochar_reg;
    assign is_summary   = osum_reg;
    assign page_count   = ocount_reg;
    assign overflow     = oovf_reg;
    assign last         = olast_reg;

endmodule

// ===== design/greedy_word_wrap_pager_unit.sv =====
// Greedy word wrap pager. Characters enter on the input channel, one per transaction, and
// are gathered into one of two word buffers; a space or null closes a word, end_of_text
// closes the text. Closed words queue up (two deep) for the layout side, which emits one
// transaction per placed cell (separating space first) and one summary transaction per text.
// The input side takes a character every cycle while a word buffer is free and the queue is
// not full. For each word the layout side takes it from the queue and places it, emits the
// separating space, then reads each character from the word buffer ram and loads it into
// the output register; it ends each text with the summary. Back pressure on the output
// holds the layout side only; configuration takes effect for the next word placed.
module greedy_word_wrap_pager_unit #(
    parameter int MAX_LINE_WIDTH = gwwp_pkg::MAX_LINE_WIDTH_DEF,
    parameter int MAX_PAGES      = gwwp_pkg::MAX_PAGES_DEF,
    parameter int MAX_ROWS       = gwwp_pkg::MAX_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gwwp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gwwp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       glyph,
    input  logic                             end_of_text,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [4:0]                       page_index,
    output logic [1:0]                       row_index,
    output logic [3:0]                       column_index,
    output logic [7:0]                       cell_char,
    output logic                             is_summary,
    output logic [5:0]                       page_count,
    output logic                             overflow,
    output logic                             last
);

    localparam int AW = $clog2(2 * MAX_LINE_WIDTH);

    gwwp_pkg::cfg_t cfg_reg;
    gwwp_pkg::cmd_t push_data;
    gwwp_pkg::cmd_t head_data;
    gwwp_pkg::rel_t rel;
    logic           push, full, pop, head_valid;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width    <= gwwp_pkg::LINE_WIDTH_RST;
            cfg_reg.rows_per_page <= gwwp_pkg::ROWS_PER_PAGE_RST;
            cfg_reg.page_limit    <= gwwp_pkg::PAGE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gwwp_pkg::REG_LINE_WIDTH:    cfg_reg.line_width    <= cfg_data[4:0];
                gwwp_pkg::REG_ROWS_PER_PAGE: cfg_reg.rows_per_page <= cfg_data[2:0];
                gwwp_pkg::REG_PAGE_LIMIT:    cfg_reg.page_limit    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gwwp_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .glyph       (glyph),
        .end_of_text (end_of_text),
        .q_push      (push),
        .q_data      (push_data),
        .q_full      (full),
        .rel         (rel),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    gwwp_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // two word buffers, one per bank
    gwwp_ram #(
        .WIDTH (8),
        .DEPTH (2 * MAX_LINE_WIDTH)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gwwp_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_PAGES      (MAX_PAGES),
        .MAX_ROWS       (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (head_valid),
        .q_data       (head_data),
        .q_pop        (pop),
        .rel          (rel),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .page_index   (page_index),
        .row_index    (row_index),
        .column_index (column_index),
        .cell_char    (cell_char),
        .is_summary   (is_summary),
        .page_count   (page_count),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

// ===== design/gwwp_checker.sv =====
// port level checks of the pager output, bound to the top level
module gwwp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] page_index,
    input logic [1:0] row_index,
    input logic [3:0] column_index,
    input logic [7:0] cell_char,
    input logic       is_summary,
    input logic [5:0] page_count,
    input logic       overflow,
    input logic       last
);

    // a stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_char) && $stable(column_index)
            && $stable(is_summary) && $stable(last))
        else $error("output transaction changed while stalled");

    // the summary always closes the text
    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_summary |-> last)
        else $error("summary without last");

    a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_summary |-> page_index == 5'd0 && row_index == 2'd0
            && column_index == 4'd0 && cell_char == 8'd0)
        else $error("summary with nonzero cell fields");

    a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_summary |-> page_count == 6'd0 && !overflow)
        else $error("cell with summary fields set");

endmodule

bind greedy_word_wrap_pager_unit gwwp_checker u_gwwp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .page_index   (page_index),
    .row_index    (row_index),
    .column_index (column_index),
    .cell_char    (cell_char),
    .is_summary   (is_summary),
    .page_count   (page_count),
    .overflow     (overflow),
    .last         (last)
);

// ===== bench/greedy_word_wrap_pager_unit_test.sv =====
// testbench for the greedy word wrap pager: directed and random texts against a layout predictor
`timescale 1ns / 100ps

module greedy_word_wrap_pager_unit_test;

    localparam int WORD_CAP         = gwwp_pkg::MAX_LINE_WIDTH_DEF;
    localparam int DRAIN_CYCLES     = 100;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [4:0] page;
        logic [1:0] row;
        logic [3:0] col;
        logic [7:0] ch;
        logic       summary;
        logic [5:0] pages_used;
        logic       dropped;
        logic       last;
    } cell_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_write   = 1'b0;
    logic [gwwp_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [gwwp_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [7:0]                       glyph       = '0;
    logic                             end_of_text = 1'b0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic [4:0]                       page_index;
    logic [1:0]                       row_index;
    logic [3:0]                       column_index;
    logic [7:0]                       cell_char;
    logic                             is_summary;
    logic [5:0]                       page_count;
    logic                             overflow;
    logic                             last;

    // layout predictor state
    gwwp_pkg::cfg_t layout_cfg;
    logic [7:0]     word_buf [WORD_CAP];
    logic [4:0]     word_len;
    logic           word_overlong;
    logic [4:0]     cur_col;
    logic [1:0]     cur_row;
    logic [5:0]     cur_page;
    logic           placed_any;
    logic           dropped_any;
    cell_t          expected_cells [$];

    int  send_idle_pct   = 32;
    int  recv_idle_pct   = 71;
    bit  long_hold_req   = 1'b0;
    int  hold_left       = 0;
    int  fail_count      = 0;
    int  glyphs_sent     = 0;
    int  cells_seen      = 0;
    int  summaries_seen  = 0;
    int  layouts_applied = 0;

    greedy_word_wrap_pager_unit dut (.*);

    always #5 clk = ~clk;

    function automatic void clear_layout();
        word_len      = '0;
        word_overlong = 1'b0;
        cur_col       = '0;
        cur_row       = '0;
        cur_page      = '0;
        placed_any    = 1'b0;
        dropped_any   = 1'b0;
    endfunction

    function automatic int eff_line_width();
        return (layout_cfg.line_width < gwwp_pkg::MAX_LINE_WIDTH_DEF)
               ? int'(layout_cfg.line_width) : gwwp_pkg::MAX_LINE_WIDTH_DEF;
    endfunction

    function automatic void push_cell(input int pg, input int row, input int col,
                                      input logic [7:0] ch);
        cell_t c;
        c      = '0;
        c.page = 5'(pg);
        c.row  = 2'(row);
        c.col  = 4'(col);
        c.ch   = ch;
        expected_cells.push_back(c);
    endfunction

    // lays out the held word and returns the number of cells it fills
    function automatic int place_word();
        int lw, rows, pl, col, row, pg, sep, w, n;
        lw   = eff_line_width();
        rows = (layout_cfg.rows_per_page == 0) ? 1 :
               (layout_cfg.rows_per_page > gwwp_pkg::MAX_ROWS_DEF) ? gwwp_pkg::MAX_ROWS_DEF
                                                         : int'(layout_cfg.rows_per_page);
        pl   = (layout_cfg.page_limit < gwwp_pkg::MAX_PAGES_DEF) ? int'(layout_cfg.page_limit)
                                                                 : gwwp_pkg::MAX_PAGES_DEF;
        col  = cur_col;
        row  = cur_row;
        pg   = cur_page;
        w    = word_len;
        n    = 0;
        if (w == 0 && !word_overlong)
            return 0;
        word_len = '0;
        if (word_overlong || w > lw)
        begin
            word_overlong = 1'b0;
            dropped_any   = 1'b1;
            return 0;
        end
        sep = (col > 0) ? 1 : 0;
        if (col + sep + w > lw)
        begin
            col = 0;
            sep = 0;
            row++;
            if (row >= rows)
            begin
                row = 0;
                pg++;
            end
        end
        // past the page limit: pin the cursor so the rest of the text drops too
        if (pg >= pl)
        begin
            dropped_any = 1'b1;
            cur_row     = 2'(rows - 1);
            cur_col     = 5'(gwwp_pkg::MAX_LINE_WIDTH_DEF);
            return 0;
        end
        if (sep != 0)
        begin
            push_cell(pg, row, col, gwwp_pkg::SEP_CODE);
            n++;
            col++;
        end
        for (int i = 0; i < w; i++)
        begin
            push_cell(pg, row, col, word_buf[i]);
            n++;
            col++;
        end
        cur_col    = 5'(col);
        cur_row    = 2'(row);
        cur_page   = 6'(pg);
        placed_any = 1'b1;
        return n;
    endfunction

    function automatic void predict_glyph(input logic [7:0] g, input logic e);
        int    n;
        cell_t c;
        n = 0;
        if (g == gwwp_pkg::SEP_CODE || g == gwwp_pkg::NUL_CODE)
            n = place_word();
        else if (word_len < WORD_CAP)
        begin
            word_buf[word_len[3:0]] = g;
            word_len++;
        end
        else
            word_overlong = 1'b1;
        if (e)
        begin
            n += place_word();
            c            = '0;
            c.summary    = 1'b1;
            c.pages_used = placed_any ? cur_page + 6'd1 : 6'd0;
            c.dropped    = dropped_any;
            expected_cells.push_back(c);
            n++;
            clear_layout();
        end
        if (n > 0)
        begin
            c      = expected_cells.pop_back();
            c.last = 1'b1;
            expected_cells.push_back(c);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        cell_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected transaction: page %0d row %0d col %0d char %0d summary %0b",
                       page_index, row_index, column_index, cell_char, is_summary);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("page_index", want.page, page_index);
                check_field("row_index", want.row, row_index);
                check_field("column_index", want.col, column_index);
                check_field("cell_char", want.ch, cell_char);
                check_field("is_summary", want.summary, is_summary);
                check_field("page_count", want.pages_used, page_count);
                check_field("overflow", want.dropped, overflow);
                check_field("last", want.last, last);
                if (want.summary)
                    summaries_seen++;
                else
                    cells_seen++;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_glyph(input logic [7:0] g, input logic e);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        glyph       <= g;
        end_of_text <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_glyph(g, e);
        glyphs_sent++;
    endtask

    task automatic send_text(input string s, input bit close_text);
        int i;
        for (i = 0; i < s.len(); i++)
            send_glyph(s[i], close_text && i == s.len() - 1);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
    endtask

    // dropped words leave no result behind, so give the layout side time to drain
    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_layout(input logic [4:0] lw, input logic [2:0] rows,
                                input logic [5:0] pl);
        cfg_write <= 1'b1;
        cfg_index <= gwwp_pkg::REG_LINE_WIDTH;
        cfg_data  <= gwwp_pkg::CFG_DATA_W'(lw);
        @(posedge clk);
        cfg_index <= gwwp_pkg::REG_ROWS_PER_PAGE;
        cfg_data  <= gwwp_pkg::CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= gwwp_pkg::REG_PAGE_LIMIT;
        cfg_data  <= gwwp_pkg::CFG_DATA_W'(pl);
        @(posedge clk);
        cfg_write <= 1'b0;
        layout_cfg.line_width    = lw;
        layout_cfg.rows_per_page = rows;
        layout_cfg.page_limit    = pl;
        layouts_applied++;
    endtask

    function automatic logic [7:0] random_word_char();
        int r;
        r = $urandom_range(99);
        // a little raw noise, separators included
        if (r < 5)
            return 8'($urandom_range(0, 255));
        else if (r < 70)
            return 8'($urandom_range(33, 126));
        else if (r < 85)
            return 8'($urandom_range(128, 255));
        else
            return 8'($urandom_range(1, 31));
    endfunction

    task automatic send_random_text();
        int   words, len, fit, r, k, s, seps;
        bit   close_on_char;
        logic [7:0] sep_char;
        if ($urandom_range(99) < 5)
        begin
            send_glyph(gwwp_pkg::SEP_CODE, 1'b1);
            return;
        end
        words         = $urandom_range(1, 8);
        close_on_char = ($urandom_range(99) < 70);
        fit           = eff_line_width();
        if (fit < 1)
            fit = 1;
        for (k = 0; k < words; k++)
        begin
            r   = $urandom_range(99);
            len = (r < 75) ? $urandom_range(1, fit) :
                  (r < 90) ? $urandom_range(1, 20) : $urandom_range(17, 20);
            for (s = 0; s < len; s++)
                send_glyph(random_word_char(),
                           close_on_char && k == words - 1 && s == len - 1);
            if (!(close_on_char && k == words - 1))
            begin
                seps = ($urandom_range(99) < 75) ? 1 : $urandom_range(1, 3);
                for (s = 0; s < seps; s++)
                begin
                    sep_char = ($urandom_range(99) < 10) ? gwwp_pkg::NUL_CODE
                                                         : gwwp_pkg::SEP_CODE;
                    send_glyph(sep_char, k == words - 1 && s == seps - 1);
                end
            end
        end
    endtask

    task automatic pick_random_layout();
        int         r;
        logic [4:0] lw;
        logic [2:0] rows;
        logic [5:0] pl;
        r    = $urandom_range(99);
        lw   = (r < 3) ? 5'd0 : (r < 10) ? 5'd31 : (r < 20) ? 5'd1 : 5'($urandom_range(2, 16));
        rows = 3'($urandom_range(0, 7));
        r    = $urandom_range(99);
        pl   = (r < 3) ? 6'd0 : (r < 10) ? 6'd63 : (r < 20) ? 6'd32 : 6'($urandom_range(1, 6));
        wait_idle();
        apply_layout(lw, rows, pl);
    endtask

    task automatic run_traffic(input int send_pct, input int recv_pct, input int quota);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = glyphs_sent;
        while (glyphs_sent - start < quota)
        begin
            if ($urandom_range(99) < 50)
                pick_random_layout();
            send_random_text();
        end
    endtask

    task automatic test_default_layout();
        send_text("ab cd", 1'b1);
    endtask

    // long word, null separator, page limit reached and every later word dropped
    task automatic test_narrow_page_limit();
        wait_idle();
        apply_layout(5'd3, 3'd1, 6'd2);
        send_text("ab", 1'b0);
        send_glyph(gwwp_pkg::NUL_CODE, 1'b0);
        send_text("abcd c d e f", 1'b1);
    endtask

    task automatic test_zero_settings();
        wait_idle();
        apply_layout(5'd0, 3'd2, 6'd20);
        send_text("a", 1'b1);
        wait_idle();
        apply_layout(5'd16, 3'd2, 6'd0);
        send_text("b", 1'b1);
        wait_idle();
        apply_layout(5'd1, 3'd0, 6'd20);
        send_text("a b", 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        apply_layout(5'd31, 3'd7, 6'd63);
        send_text("xyz", 1'b1);
        // empty text
        send_glyph(gwwp_pkg::SEP_CODE, 1'b1);
    endtask

    task automatic test_config_mid_text();
        wait_idle();
        apply_layout(5'd16, 3'd2, 6'd20);
        send_text("ab c", 1'b0);
        wait_idle();
        apply_layout(5'd4, 3'd2, 6'd20);
        send_text("d", 1'b1);
    endtask

    // one-character words on one-row pages run through every page up to the limit
    task automatic test_page_span();
        int k;
        wait_idle();
        apply_layout(5'd1, 3'd1, 6'd32);
        for (k = 0; k < 33; k++)
        begin
            send_glyph(8'($urandom_range(33, 126)), 1'b0);
            send_glyph(gwwp_pkg::SEP_CODE, k == 32);
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(32, 71, 55);
        run_traffic(71, 32, 55);
        run_traffic(0, 0, 55);
    endtask

    task automatic test_output_hold();
        wait_idle();
        apply_layout(5'd16, 3'd4, 6'd32);
        long_hold_req = 1'b1;
        repeat (2) send_random_text();
    endtask

    task automatic test_sender_pause();
        send_text("abc def", 1'b0);
        wait_results();
        send_text(" gh", 1'b1);
    endtask

    initial
    begin
        clear_layout();
        layout_cfg = {gwwp_pkg::LINE_WIDTH_RST, gwwp_pkg::ROWS_PER_PAGE_RST,
                      gwwp_pkg::PAGE_LIMIT_RST};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_layout();
        test_narrow_page_limit();
        test_zero_settings();
        test_register_extremes();
        test_config_mid_text();
        test_page_span();
        test_random_traffic();
        test_output_hold();
        test_sender_pause();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d characters under %0d layout settings", glyphs_sent, layouts_applied);
        $display("checked %0d placed cells and %0d text summaries", cells_seen, summaries_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", expected_cells.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== greedy_word_wrap_pager_unit.f =====
design/gwwp_pkg.sv
design/gwwp_ram.sv
design/gwwp_front.sv
design/gwwp_cmd_fifo.sv
design/gwwp_back.sv
design/greedy_word_wrap_pager_unit.sv
design/gwwp_checker.sv
bench/greedy_word_wrap_pager_unit_test.sv
